>>> hw/rtl/c8_pkg.sv
// Shared constants, types and helper function of the CHIP-8 instruction core.
// Used by c8_alu, chip8_instruction_core and c8_chk; no dependencies.
package c8_pkg;

    localparam int RAM_BYTES   = 4096;
    localparam int SCREEN_W    = 64;
    localparam int SCREEN_H    = 32;
    localparam int STACK_DEPTH = 16;
    localparam int START_PC    = 512;
    localparam int FONT_BYTES  = 80;

    // stream item layout
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 112;

    // commands carried in tuser
    localparam logic [1:0] CMD_STEP = 2'd0;
    localparam logic [1:0] CMD_WR   = 2'd1;
    localparam logic [1:0] CMD_RD   = 2'd2;
    localparam logic [1:0] CMD_ROW  = 2'd3;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OVF  = 2'd1;
    localparam logic [1:0] FAULT_UNF  = 2'd2;

    // major opcode nibble
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEK  = 4'h3;
    localparam logic [3:0] OP_SNEK = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LDK  = 4'h6;
    localparam logic [3:0] OP_ADDK = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // 8xyN sub-operations
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] MISC_GDT  = 8'h07;
    localparam logic [7:0] MISC_WKEY = 8'h0A;
    localparam logic [7:0] MISC_SDT  = 8'h15;
    localparam logic [7:0] MISC_SST  = 8'h18;
    localparam logic [7:0] MISC_ADDI = 8'h1E;
    localparam logic [7:0] MISC_FONT = 8'h29;
    localparam logic [7:0] MISC_BCD  = 8'h33;
    localparam logic [7:0] MISC_STR  = 8'h55;
    localparam logic [7:0] MISC_LDR  = 8'h65;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [7:0] res;
        logic       wr_x;
        logic       flag;
        logic       wr_f;
        logic       f_first;
    } t_alu_out;

    // decimal digits of a byte: {hundreds, tens, ones}, 4 bits each
    function automatic logic [11:0] bcd3(input logic [7:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [7:0] r;
        h = 4'd0;
        t = 4'd0;
        r = v;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end
        for (int k = 1; k <= 9; k++) begin
            if (r >= 8'(k * 10)) t = 4'(k);
        end
        r = r - 8'({t, 3'b000} + {t, 1'b0});
        return {h, t, r[3:0]};
    endfunction

endpackage

>>> hw/rtl/chip8_instruction_core.sv
// CHIP-8 instruction core: sequencer around RAM, frame buffer, V registers and stack.
// Depends on c8_pkg, c8_ram and c8_alu.
//
// Usage:
//   Slave stream carries one command per transaction (tuser = command):
//   execute one instruction, write a RAM byte, read a RAM byte or read a
//   64-pixel screen row. Every transaction yields exactly one master
//   transaction with pc, I, both timers, read data, key-wait and fault.
//   An instruction passes through accept, fetch of two bytes and Vx, Vy, V0
//   operand reads through the one read port of each memory, execute and
//   output, plus a second register write for results with a flag, a stack
//   read for 00EE, the digit writes for Fx33, the transfers for Fx55/Fx65,
//   the Dxyn sprite rows left after clipping (one per cycle) and the 00E0
//   clear (one frame-buffer row per cycle).
//   One item is in work at a time; a new command is taken once the previous
//   one has been handed to the output register, so a stalled receiver holds
//   the result and the core waits before finishing the next one.
//   Reset: synchronous, active low. Afterwards a sweep writes the font and
//   zeros to RAM and clears the screen and V registers; o_s_tready stays
//   low during the sweep.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH,
    parameter int START_PC    = c8_pkg::START_PC
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // keys[15:0], rand_byte[23:16], addr[35:24], data[43:36], zero fill
    input  logic [c8_pkg::S_DATA_W-1:0] i_s_tdata,
    // cmd[1:0]
    input  logic [1:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // prog_counter[11:0], index_reg[23:12], delay_value[31:24], sound_value[39:32],
    // read_data[103:40], waiting_key[104], fault[106:105], zero fill
    output logic [c8_pkg::M_DATA_W-1:0] o_m_tdata
);

    localparam int SPW = $clog2(STACK_DEPTH);

    localparam logic [4:0] ST_INIT = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_RDW  = 5'd2;
    localparam logic [4:0] ST_F1   = 5'd3;
    localparam logic [4:0] ST_F2   = 5'd4;
    localparam logic [4:0] ST_F3   = 5'd5;
    localparam logic [4:0] ST_F4   = 5'd6;
    localparam logic [4:0] ST_F5   = 5'd7;
    localparam logic [4:0] ST_EX   = 5'd8;
    localparam logic [4:0] ST_WB2  = 5'd9;
    localparam logic [4:0] ST_RET  = 5'd10;
    localparam logic [4:0] ST_CLS  = 5'd11;
    localparam logic [4:0] ST_BCD  = 5'd12;
    localparam logic [4:0] ST_STR  = 5'd13;
    localparam logic [4:0] ST_LDR  = 5'd14;
    localparam logic [4:0] ST_DRAW = 5'd15;
    localparam logic [4:0] ST_FIN  = 5'd16;

    logic [4:0]  r_state, n_state;
    logic [11:0] r_cnt, n_cnt;
    logic [11:0] r_pc, n_pc;
    logic [11:0] r_i, n_i;
    logic [7:0]  r_dt, n_dt;
    logic [7:0]  r_st, n_st;
    logic [4:0]  r_sp, n_sp;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [7:0]  r_v0, n_v0;
    logic [1:0]  r_cmd, n_cmd;
    logic [15:0] r_keys, n_keys;
    logic [7:0]  r_rnd, n_rnd;
    logic [11:0] r_addr, n_addr;
    logic [63:0] r_rd, n_rd;
    logic        r_wait, n_wait;
    logic [1:0]  r_fault, n_fault;
    logic        r_coll, n_coll;
    logic        r_dv, n_dv;
    logic [4:0]  r_drow, n_drow;
    logic [3:0]  r_wb_idx, n_wb_idx;
    logic [7:0]  r_wb_val, n_wb_val;
    logic        r_o_valid, n_o_valid;
    logic [c8_pkg::M_DATA_W-1:0] r_o_data, n_o_data;

    // memory ports
    logic              ram_we;
    logic [11:0]       ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_q;
    logic              fb_we;
    logic [4:0]        fb_waddr, fb_raddr;
    logic [63:0]       fb_wdata, fb_q;
    logic              vr_we;
    logic [3:0]        vr_waddr, vr_raddr;
    logic [7:0]        vr_wdata, vr_q;
    logic              stk_we;
    logic [SPW-1:0]    stk_waddr, stk_raddr;
    logic [11:0]       stk_wdata, stk_q;

    c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::RAM_BYTES)) u_main_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_q)
    );

    c8_ram #(.WIDTH(c8_pkg::SCREEN_W), .DEPTH(c8_pkg::SCREEN_H)) u_frame_ram (
        .i_clk(i_clk), .i_we(fb_we), .i_waddr(fb_waddr), .i_wdata(fb_wdata),
        .i_raddr(fb_raddr), .o_rdata(fb_q)
    );

    c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg_ram (
        .i_clk(i_clk), .i_we(vr_we), .i_waddr(vr_waddr), .i_wdata(vr_wdata),
        .i_raddr(vr_raddr), .o_rdata(vr_q)
    );

    c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_q)
    );

    c8_pkg::t_alu_out alu;

    c8_alu u_alu (
        .i_major(r_op[15:12]),
        .i_minor(r_op[3:0]),
        .i_vx(r_vx),
        .i_vy(r_vy),
        .i_kk(r_op[7:0]),
        .i_rnd(r_rnd),
        .o_res(alu)
    );

    logic        accept;
    logic [3:0]  op_x;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    logic [3:0]  key_enc;
    logic        key_any;
    logic        key_hit;
    logic [11:0] bcd;
    logic [4:0]  sp_inc;
    logic [4:0]  cnt5;
    logic [5:0]  draw_sum;
    logic        draw_issue;
    logic [63:0] sprite_bits;
    logic        out_free;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign op_x       = r_op[11:8];
    assign op_kk      = r_op[7:0];
    assign op_nnn     = r_op[11:0];
    assign key_hit    = r_keys[r_vx[3:0]];
    assign bcd        = c8_pkg::bcd3(r_vx);
    assign sp_inc     = r_sp + 5'd1;
    assign cnt5       = r_cnt[4:0];
    assign draw_sum   = {1'b0, r_vy[4:0]} + {1'b0, cnt5};
    assign draw_issue = (cnt5 < {1'b0, r_op[3:0]}) && (draw_sum < 6'(c8_pkg::SCREEN_H));
    assign sprite_bits = {ram_q, 56'd0} >> r_vx[5:0];
    assign out_free   = !r_o_valid || i_m_tready;

    // lowest pressed key
    always_comb begin
        key_enc = 4'd0;
        key_any = |r_keys;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) key_enc = 4'(k);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pc     = r_pc;
        n_i      = r_i;
        n_dt     = r_dt;
        n_st     = r_st;
        n_sp     = r_sp;
        n_op     = r_op;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_v0     = r_v0;
        n_cmd    = r_cmd;
        n_keys   = r_keys;
        n_rnd    = r_rnd;
        n_addr   = r_addr;
        n_rd     = r_rd;
        n_wait   = r_wait;
        n_fault  = r_fault;
        n_coll   = r_coll;
        n_dv     = r_dv;
        n_drow   = r_drow;
        n_wb_idx = r_wb_idx;
        n_wb_val = r_wb_val;

        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = 8'd0;
        ram_raddr = r_pc;
        fb_we     = 1'b0;
        fb_waddr  = r_drow;
        fb_wdata  = '0;
        fb_raddr  = r_addr[4:0];
        vr_we     = 1'b0;
        vr_waddr  = op_x;
        vr_wdata  = 8'd0;
        vr_raddr  = op_x;
        stk_we    = 1'b0;
        stk_waddr = r_sp[SPW-1:0];
        stk_wdata = r_pc;
        stk_raddr = sp_inc[SPW-1:0];

        unique case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = (r_cnt < 12'(c8_pkg::FONT_BYTES)) ?
                            c8_pkg::FONT[r_cnt[6:0]] : 8'd0;
                fb_we     = (r_cnt < 12'(c8_pkg::SCREEN_H));
                fb_waddr  = cnt5;
                vr_we     = (r_cnt < 12'd16);
                vr_waddr  = r_cnt[3:0];
                n_cnt     = r_cnt + 12'd1;
                if (r_cnt == 12'(c8_pkg::RAM_BYTES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_s_tuser;
                    n_keys  = i_s_tdata[15:0];
                    n_rnd   = i_s_tdata[23:16];
                    n_addr  = i_s_tdata[35:24];
                    n_rd    = '0;
                    n_wait  = 1'b0;
                    n_fault = c8_pkg::FAULT_NONE;
                    unique case (i_s_tuser)
                        c8_pkg::CMD_STEP: begin
                            ram_raddr = r_pc;
                            n_state   = ST_F1;
                        end
                        c8_pkg::CMD_WR: begin
                            ram_we    = 1'b1;
                            ram_waddr = i_s_tdata[35:24];
                            ram_wdata = i_s_tdata[43:36];
                            n_state   = ST_FIN;
                        end
                        c8_pkg::CMD_RD: begin
                            ram_raddr = i_s_tdata[35:24];
                            n_state   = ST_RDW;
                        end
                        c8_pkg::CMD_ROW: begin
                            fb_raddr = i_s_tdata[28:24];
                            n_state  = ST_RDW;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RDW: begin
                if (r_cmd == c8_pkg::CMD_RD) n_rd = {56'd0, ram_q};
                else if (r_addr[11:5] == 7'd0) n_rd = fb_q;
                else n_rd = '0;
                n_state = ST_FIN;
            end
            ST_F1: begin
                n_op[15:8] = ram_q;
                ram_raddr  = r_pc + 12'd1;
                n_state    = ST_F2;
            end
            ST_F2: begin
                n_op[7:0] = ram_q;
                vr_raddr  = r_op[11:8];
                n_pc      = r_pc + 12'd2;
                n_state   = ST_F3;
            end
            ST_F3: begin
                n_vx     = vr_q;
                vr_raddr = r_op[7:4];
                n_state  = ST_F4;
            end
            ST_F4: begin
                n_vy     = vr_q;
                vr_raddr = 4'd0;
                n_state  = ST_F5;
            end
            ST_F5: begin
                n_v0    = vr_q;
                n_state = ST_EX;
            end
            ST_EX: begin
                n_state = ST_FIN;
                n_cnt   = 12'd0;
                unique case (r_op[15:12])
                    c8_pkg::OP_SYS: begin
                        if (op_nnn == c8_pkg::SYS_CLS) begin
                            n_state = ST_CLS;
                        end else if (op_nnn == c8_pkg::SYS_RET) begin
                            if (r_sp == 5'(STACK_DEPTH - 1)) begin
                                n_fault = c8_pkg::FAULT_UNF;
                            end else begin
                                n_sp      = sp_inc;
                                stk_raddr = sp_inc[SPW-1:0];
                                n_state   = ST_RET;
                            end
                        end
                    end
                    c8_pkg::OP_JP: n_pc = op_nnn;
                    c8_pkg::OP_CALL: begin
                        if (r_sp >= 5'(STACK_DEPTH)) begin
                            n_fault = c8_pkg::FAULT_OVF;
                        end else begin
                            stk_we = 1'b1;
                            n_sp   = (r_sp == 5'd0) ? 5'd31 : r_sp - 5'd1;
                            n_pc   = op_nnn;
                        end
                    end
                    c8_pkg::OP_SEK:  if (r_vx == op_kk) n_pc = r_pc + 12'd2;
                    c8_pkg::OP_SNEK: if (r_vx != op_kk) n_pc = r_pc + 12'd2;
                    c8_pkg::OP_SEV:  if (r_vx == r_vy) n_pc = r_pc + 12'd2;
                    c8_pkg::OP_SNEV: if (r_vx != r_vy) n_pc = r_pc + 12'd2;
                    c8_pkg::OP_LDK, c8_pkg::OP_ADDK, c8_pkg::OP_RND, c8_pkg::OP_ALU: begin
                        if (alu.wr_f && alu.f_first) begin
                            vr_we    = 1'b1;
                            vr_waddr = 4'hF;
                            vr_wdata = {7'd0, alu.flag};
                            n_wb_idx = op_x;
                            n_wb_val = alu.res;
                            n_state  = ST_WB2;
                        end else if (alu.wr_x) begin
                            vr_we    = 1'b1;
                            vr_wdata = alu.res;
                            if (alu.wr_f) begin
                                n_wb_idx = 4'hF;
                                n_wb_val = {7'd0, alu.flag};
                                n_state  = ST_WB2;
                            end
                        end
                    end
                    c8_pkg::OP_LDI:  n_i = op_nnn;
                    c8_pkg::OP_JPV0: n_pc = op_nnn + {4'd0, r_v0};
                    c8_pkg::OP_DRW: begin
                        n_coll  = 1'b0;
                        n_dv    = 1'b0;
                        n_state = ST_DRAW;
                    end
                    c8_pkg::OP_KEY: begin
                        if (op_kk == c8_pkg::KEY_SKP && key_hit) n_pc = r_pc + 12'd2;
                        if (op_kk == c8_pkg::KEY_SKNP && !key_hit) n_pc = r_pc + 12'd2;
                    end
                    c8_pkg::OP_MISC: begin
                        unique case (op_kk)
                            c8_pkg::MISC_GDT: begin
                                vr_we    = 1'b1;
                                vr_wdata = r_dt;
                            end
                            c8_pkg::MISC_WKEY: begin
                                if (key_any) begin
                                    vr_we    = 1'b1;
                                    vr_wdata = {4'd0, key_enc};
                                end else begin
                                    n_pc   = r_pc - 12'd2;
                                    n_wait = 1'b1;
                                end
                            end
                            c8_pkg::MISC_SDT:  n_dt = r_vx;
                            c8_pkg::MISC_SST:  n_st = r_vx;
                            c8_pkg::MISC_ADDI: n_i = r_i + {4'd0, r_vx};
                            c8_pkg::MISC_FONT:
                                n_i = {2'd0, r_vx, 2'd0} + {4'd0, r_vx};
                            c8_pkg::MISC_BCD:  n_state = ST_BCD;
                            c8_pkg::MISC_STR:  n_state = ST_STR;
                            c8_pkg::MISC_LDR:  n_state = ST_LDR;
                            default:           n_state = ST_FIN;
                        endcase
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_WB2: begin
                vr_we    = 1'b1;
                vr_waddr = r_wb_idx;
                vr_wdata = r_wb_val;
                n_state  = ST_FIN;
            end
            ST_RET: begin
                n_pc    = stk_q;
                n_state = ST_FIN;
            end
            ST_CLS: begin
                fb_we    = 1'b1;
                fb_waddr = cnt5;
                n_cnt    = r_cnt + 12'd1;
                if (cnt5 == 5'(c8_pkg::SCREEN_H - 1)) n_state = ST_FIN;
            end
            ST_BCD: begin
                ram_we    = 1'b1;
                ram_waddr = r_i + {10'd0, r_cnt[1:0]};
                unique case (r_cnt[1:0])
                    2'd0:    ram_wdata = {4'd0, bcd[11:8]};
                    2'd1:    ram_wdata = {4'd0, bcd[7:4]};
                    default: ram_wdata = {4'd0, bcd[3:0]};
                endcase
                n_cnt = r_cnt + 12'd1;
                if (r_cnt[1:0] == 2'd2) n_state = ST_FIN;
            end
            ST_STR: begin
                // read V[c] while V[c-1] goes to RAM
                vr_raddr  = cnt5[3:0];
                ram_we    = (cnt5 != 5'd0);
                ram_waddr = r_i + {7'd0, cnt5} - 12'd1;
                ram_wdata = vr_q;
                n_cnt     = r_cnt + 12'd1;
                if (cnt5 == {1'b0, op_x} + 5'd1) n_state = ST_FIN;
            end
            ST_LDR: begin
                ram_raddr = r_i + {7'd0, cnt5};
                vr_we     = (cnt5 != 5'd0);
                vr_waddr  = 4'(cnt5 - 5'd1);
                vr_wdata  = ram_q;
                n_cnt     = r_cnt + 12'd1;
                if (cnt5 == {1'b0, op_x} + 5'd1) n_state = ST_FIN;
            end
            ST_DRAW: begin
                // issue row c, xor row c-1 back
                ram_raddr = r_i + {7'd0, cnt5};
                fb_raddr  = draw_sum[4:0];
                if (r_dv) begin
                    fb_we    = 1'b1;
                    fb_waddr = r_drow;
                    fb_wdata = fb_q ^ sprite_bits;
                    if ((fb_q & sprite_bits) != '0) n_coll = 1'b1;
                end
                n_dv   = draw_issue;
                n_drow = draw_sum[4:0];
                n_cnt  = r_cnt + 12'd1;
                if (!draw_issue && !r_dv) begin
                    vr_we    = 1'b1;
                    vr_waddr = 4'hF;
                    vr_wdata = {7'd0, r_coll};
                    n_state  = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        if (r_o_valid && i_m_tready) n_o_valid = 1'b0;
        if (r_state == ST_FIN && out_free) begin
            n_o_valid = 1'b1;
            n_o_data  = {5'd0, r_fault, r_wait, r_rd, r_st, r_dt, r_i, r_pc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= 12'd0;
            r_pc      <= 12'(START_PC);
            r_i       <= 12'd0;
            r_dt      <= 8'd0;
            r_st      <= 8'd0;
            r_sp      <= 5'(STACK_DEPTH - 1);
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pc      <= n_pc;
            r_i       <= n_i;
            r_dt      <= n_dt;
            r_st      <= n_st;
            r_sp      <= n_sp;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_v0     <= n_v0;
        r_cmd    <= n_cmd;
        r_keys   <= n_keys;
        r_rnd    <= n_rnd;
        r_addr   <= n_addr;
        r_rd     <= n_rd;
        r_wait   <= n_wait;
        r_fault  <= n_fault;
        r_coll   <= n_coll;
        r_drow   <= n_drow;
        r_wb_idx <= n_wb_idx;
        r_wb_val <= n_wb_val;
        r_o_data <= n_o_data;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

endmodule

>>> hw/rtl/c8_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/c8_alu.sv
// Register arithmetic for 6xkk, 7xkk, Cxkk and the 8xyN group.
// Depends on c8_pkg.
module c8_alu (
    input  logic [3:0]        i_major,
    input  logic [3:0]        i_minor,
    input  logic [7:0]        i_vx,
    input  logic [7:0]        i_vy,
    input  logic [7:0]        i_kk,
    input  logic [7:0]        i_rnd,
    output c8_pkg::t_alu_out  o_res
);

    logic [8:0] sum;

    assign sum = {1'b0, i_vx} + {1'b0, i_vy};

    always_comb begin
        o_res = '0;
        unique case (i_major)
            c8_pkg::OP_LDK: begin
                o_res.res  = i_kk;
                o_res.wr_x = 1'b1;
            end
            c8_pkg::OP_ADDK: begin
                o_res.res  = i_vx + i_kk;
                o_res.wr_x = 1'b1;
            end
            c8_pkg::OP_RND: begin
                o_res.res  = i_rnd & i_kk;
                o_res.wr_x = 1'b1;
            end
            c8_pkg::OP_ALU: begin
                unique case (i_minor)
                    c8_pkg::ALU_MOV: begin
                        o_res.res = i_vy; o_res.wr_x = 1'b1;
                    end
                    c8_pkg::ALU_OR: begin
                        o_res.res = i_vx | i_vy; o_res.wr_x = 1'b1;
                    end
                    c8_pkg::ALU_AND: begin
                        o_res.res = i_vx & i_vy; o_res.wr_x = 1'b1;
                    end
                    c8_pkg::ALU_XOR: begin
                        o_res.res = i_vx ^ i_vy; o_res.wr_x = 1'b1;
                    end
                    c8_pkg::ALU_ADD: begin
                        // carry goes to VF after Vx
                        o_res.res  = sum[7:0];
                        o_res.wr_x = 1'b1;
                        o_res.flag = sum[8];
                        o_res.wr_f = 1'b1;
                    end
                    c8_pkg::ALU_SUB: begin
                        o_res.res     = i_vx - i_vy;
                        o_res.wr_x    = 1'b1;
                        o_res.flag    = i_vx > i_vy;
                        o_res.wr_f    = 1'b1;
                        o_res.f_first = 1'b1;
                    end
                    c8_pkg::ALU_SHR: begin
                        o_res.res     = {1'b0, i_vx[7:1]};
                        o_res.wr_x    = 1'b1;
                        o_res.flag    = i_vx[0];
                        o_res.wr_f    = 1'b1;
                        o_res.f_first = 1'b1;
                    end
                    c8_pkg::ALU_SBN: begin
                        o_res.res     = i_vy - i_vx;
                        o_res.wr_x    = 1'b1;
                        o_res.flag    = i_vy > i_vx;
                        o_res.wr_f    = 1'b1;
                        o_res.f_first = 1'b1;
                    end
                    c8_pkg::ALU_SHL: begin
                        o_res.res     = {i_vx[6:0], 1'b0};
                        o_res.wr_x    = 1'b1;
                        o_res.flag    = i_vx[7];
                        o_res.wr_f    = 1'b1;
                        o_res.f_first = 1'b1;
                    end
                    default: o_res = '0;
                endcase
            end
            default: o_res = '0;
        endcase
    end

endmodule

>>> hw/rtl/c8_chk.sv
// Port-level checker for chip8_instruction_core, bound to the top level.
// Depends on c8_pkg.
module c8_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [c8_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic [1:0]                  i_s_tuser,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [c8_pkg::M_DATA_W-1:0] o_m_tdata
);

    // init sweep keeps the input closed right after reset
    a_init_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[106:105] != 2'd3)
        else $error("illegal fault code");

    a_wait_vs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[104] |-> o_m_tdata[106:105] == c8_pkg::FAULT_NONE)
        else $error("key wait reported together with a stack fault");

endmodule

bind chip8_instruction_core c8_chk u_c8_chk (.*);
